FILE: hdl/hkvt_pkg.sv
// ----------------------------------------------------------------------------
// hkvt_pkg
// Shared types and constants for the hashed key-value table.
// ----------------------------------------------------------------------------
package hkvt_pkg;

    localparam int NUM_BUCKETS_DEF = 1024;
    localparam int WAYS_DEF        = 4;

    localparam int KEY_W  = 32;
    localparam int VAL_W  = 32;
    localparam int MODE_W = 2;

    // Multiplicative hash, product wrapped to the key width
    localparam logic [KEY_W-1:0] HASH_MULT  = 32'd1009;
    localparam logic [VAL_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

    // Request codes
    localparam logic [MODE_W-1:0] MODE_PUT    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_GET    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]       mode;
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic                    found;
        logic signed [VAL_W-1:0] read_value;
        logic                    bucket_full;
    } t_rsp;

    // Controller to datapath
    typedef struct packed {
        logic load;      // capture request, start hash
        logic rd_en;     // read bucket row
        logic wb;        // write back updated row
        logic out_load;  // load response register
        logic clr_step;  // clear one valid row
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;
        logic hash_done;
    } t_sts;

endpackage

FILE: hdl/hkvt_dp.sv
// ----------------------------------------------------------------------------
// hkvt_dp
// Datapath: hash unit, bucket row memories, way compare and response register.
// ----------------------------------------------------------------------------
module hkvt_dp #(
    parameter int NUM_BUCKETS = hkvt_pkg::NUM_BUCKETS_DEF,
    parameter int WAYS        = hkvt_pkg::WAYS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  hkvt_pkg::t_cmd  i_cmd,
    input  hkvt_pkg::t_req  i_req,
    output hkvt_pkg::t_sts  o_sts,
    output hkvt_pkg::t_rsp  o_rsp
);
    import hkvt_pkg::*;

    localparam int  BW    = $clog2(NUM_BUCKETS);
    localparam int  WIX_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam bit  POW2  = ((NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0);

    typedef logic [WAYS-1:0][KEY_W-1:0] t_krow;
    typedef logic [WAYS-1:0][VAL_W-1:0] t_drow;

    // Bucket row memories
    logic [WAYS-1:0] r_vld_mem [NUM_BUCKETS];
    t_krow           r_key_mem [NUM_BUCKETS];
    t_drow           r_val_mem [NUM_BUCKETS];

    logic [MODE_W-1:0] r_mode;
    logic [KEY_W-1:0]  r_key;
    logic [VAL_W-1:0]  r_value;
    logic [KEY_W-1:0]  w_prod;
    logic [BW-1:0]     w_bucket;
    logic              w_hash_done;

    logic [BW-1:0]     r_bucket;
    logic [WAYS-1:0]   r_vrow;
    t_krow             r_krow;
    t_drow             r_drow;

    logic [BW-1:0]     r_clr_addr;

    logic [WAYS-1:0]   w_hit;
    logic              w_any_hit;
    logic              w_any_free;
    logic [WIX_W-1:0]  w_hit_idx;
    logic [WIX_W-1:0]  w_free_idx;

    logic [WAYS-1:0]   n_vrow;
    t_krow             n_krow;
    t_drow             n_drow;
    t_rsp              n_rsp;
    t_rsp              r_rsp;

    assign w_prod = KEY_W'(unsigned'(i_req.key) * HASH_MULT);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= i_req.mode;
            r_key   <= i_req.key;
            r_value <= i_req.value;
        end
    end

    // Bucket index: mask for a power-of-two count, else a three-step
    // reciprocal remainder (split multiply, shift, multiply-back and subtract)
    if (POW2) begin : g_mask
        logic [KEY_W-1:0] r_prod;

        always_ff @(posedge i_clk) begin
            if (i_cmd.load) begin
                r_prod <= w_prod;
            end
        end

        assign w_bucket    = r_prod[BW-1:0];
        assign w_hash_done = 1'b1;
    end else begin : g_mod
        // q = (x * RECIP) >> (KEY_W + BW) is exact for every 32-bit x
        localparam logic [63:0] RECIP_FULL =
            ((64'd1 << (KEY_W + BW)) / 64'(NUM_BUCKETS)) + 64'd1;
        localparam logic [16:0] RECIP_LO = RECIP_FULL[16:0];
        localparam logic [15:0] RECIP_HI = RECIP_FULL[32:17];
        localparam int          PLO_W    = KEY_W + 17;
        localparam int          PHI_W    = KEY_W + 16;
        localparam int          SUM_W    = KEY_W + 33;

        logic [1:0]       r_phase;
        logic [KEY_W-1:0] r_x;
        logic [PLO_W-1:0] r_plo;
        logic [PHI_W-1:0] r_phi;
        logic [KEY_W-1:0] r_quo;
        logic [BW-1:0]    r_rem;
        logic [SUM_W-1:0] w_sum;
        logic [BW-1:0]    w_qn;

        assign w_sum = {r_phi, 17'd0} + SUM_W'(r_plo);
        // remainder is below NUM_BUCKETS, so the low BW bits suffice
        assign w_qn  = r_quo[BW-1:0] * BW'(NUM_BUCKETS);

        always_ff @(posedge i_clk) begin
            if (i_cmd.load) begin
                r_x <= w_prod;
            end
            r_plo <= r_x * RECIP_LO;
            r_phi <= r_x * RECIP_HI;
            r_quo <= KEY_W'(w_sum >> (KEY_W + BW));
            r_rem <= r_x[BW-1:0] - w_qn;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_phase <= 2'd0;
            end else if (i_cmd.load) begin
                r_phase <= 2'd1;
            end else if (r_phase != 2'd0) begin
                r_phase <= r_phase + 2'd1;
            end
        end

        assign w_bucket    = r_rem;
        assign w_hash_done = (r_phase == 2'd0);
    end

    // Clear sweep address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // Way compare on the registered row
    always_comb begin
        w_hit_idx  = '0;
        w_free_idx = '0;
        for (int w = 0; w < WAYS; w++) begin
            w_hit[w] = r_vrow[w] && (r_krow[w] == r_key);
        end
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (w_hit[w]) begin
                w_hit_idx = WIX_W'(w);
            end
            if (!r_vrow[w]) begin
                w_free_idx = WIX_W'(w);
            end
        end
        w_any_hit  = |w_hit;
        w_any_free = !(&r_vrow);
    end

    // Row update and response
    always_comb begin
        n_vrow = r_vrow;
        n_krow = r_krow;
        n_drow = r_drow;
        n_rsp  = '0;
        unique case (r_mode)
            MODE_PUT: begin
                if (w_any_hit) begin
                    n_rsp.found       = 1'b1;
                    n_drow[w_hit_idx] = r_value;
                end else if (w_any_free) begin
                    n_krow[w_free_idx] = r_key;
                    n_drow[w_free_idx] = r_value;
                    n_vrow[w_free_idx] = 1'b1;
                end else begin
                    n_rsp.bucket_full = 1'b1;
                end
            end
            MODE_GET: begin
                if (w_any_hit) begin
                    n_rsp.found      = 1'b1;
                    n_rsp.read_value = r_drow[w_hit_idx];
                end else begin
                    n_rsp.read_value = MISS_VALUE;
                end
            end
            MODE_REMOVE: begin
                if (w_any_hit) begin
                    n_rsp.found       = 1'b1;
                    n_vrow[w_hit_idx] = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // Memory ports and row registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            r_vld_mem[r_clr_addr] <= '0;
        end else if (i_cmd.wb) begin
            r_vld_mem[r_bucket] <= n_vrow;
        end
        if (i_cmd.wb) begin
            r_key_mem[r_bucket] <= n_krow;
            r_val_mem[r_bucket] <= n_drow;
        end
        if (i_cmd.rd_en) begin
            r_bucket <= w_bucket;
            r_vrow   <= r_vld_mem[w_bucket];
            r_krow   <= r_key_mem[w_bucket];
            r_drow   <= r_val_mem[w_bucket];
        end
        if (i_cmd.out_load) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_sts.clr_last  = (r_clr_addr == BW'(NUM_BUCKETS - 1));
    assign o_sts.hash_done = w_hash_done;
    assign o_rsp           = r_rsp;

endmodule

FILE: hdl/hkvt_ctrl.sv
// ----------------------------------------------------------------------------
// hkvt_ctrl
// Controller: clear sweep, request sequencing and response valid.
// ----------------------------------------------------------------------------
module hkvt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    output logic            o_rsp_valid,
    input  logic            i_rsp_ready,
    input  hkvt_pkg::t_sts  i_sts,
    output hkvt_pkg::t_cmd  o_cmd
);
    import hkvt_pkg::*;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_CMP
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_rsp_ready;

    always_comb begin
        o_req_ready    = (r_state == S_IDLE);
        o_cmd.load     = o_req_ready && i_req_valid;
        o_cmd.rd_en    = (r_state == S_HASH) && i_sts.hash_done;
        o_cmd.wb       = (r_state == S_CMP) && w_out_free;
        o_cmd.out_load = o_cmd.wb;
        o_cmd.clr_step = (r_state == S_CLEAR);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (i_sts.clr_last) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_state <= S_HASH;
                    end
                end
                S_HASH: begin
                    if (i_sts.hash_done) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp_valid = r_out_valid;

endmodule

FILE: hdl/hashed_key_value_table_top.sv
// Sequence: a transferred request is hashed (a mask when NUM_BUCKETS is a power
//   of two, else a 3-step remainder), then its bucket row is read, then the
//   compare/write-back loads the response register, waiting while the previous
//   response is still held. No new request is taken until the write-back.
// Reset: synchronous; afterwards a clearing pass empties every way, with
//   o_req_ready held low throughout.
// ----------------------------------------------------------------------------
// hashed_key_value_table_top
// Hashed key-value table, fixed ways per bucket, put/get/remove requests.
// ----------------------------------------------------------------------------
module hashed_key_value_table_top #(
    parameter int NUM_BUCKETS = hkvt_pkg::NUM_BUCKETS_DEF,
    parameter int WAYS        = hkvt_pkg::WAYS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    // request channel
    input  logic            i_req_valid,
    output logic            o_req_ready,
    input  hkvt_pkg::t_req  i_req,
    // response channel
    output logic            o_rsp_valid,
    input  logic            i_rsp_ready,
    output hkvt_pkg::t_rsp  o_rsp
);
    import hkvt_pkg::*;

    // Command and status between controller and datapath
    t_cmd w_cmd;
    t_sts w_sts;

    // Controller: clear sweep after reset, then one request at a time.
    // The response register frees the request side: a new request transfer
    // may happen while the previous response is still waiting.
    hkvt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // Datapath: hash, row memories (valid, key, value), compare, write-back.
    // Whole bucket rows are read, modified and written back, so each
    // memory has a single read and a single write port.
    hkvt_dp #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .WAYS        (WAYS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_req   (i_req),
        .o_sts   (w_sts),
        .o_rsp   (o_rsp)
    );

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // One request in flight: no back-to-back request transfers
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready) |=> !o_req_ready)
        else $error("request accepted while another in flight");

    // A dropped put never reports a hit or a value
    a_full_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.bucket_full) |-> (!o_rsp.found && (o_rsp.read_value == 0)))
        else $error("bucket_full response carries hit or value");

    // Clear sweep and write-back never share the valid memory port
    a_port_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.clr_step && w_cmd.wb))
        else $error("clear and write-back in the same cycle");

    // No request is taken during the clearing pass
    a_no_req_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.clr_step |-> !o_req_ready)
        else $error("request ready during clearing pass");

endmodule

FILE: tb/sv/tb_hashed_key_value_table_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hashed_key_value_table_top
// Self-checking bench for the hashed key-value table. A short scripted run
// covers empty, full and overwritten buckets, removes and the unused mode.
// A long random run follows, with keys drawn from a few colliding buckets.
// Every response is checked against a behavioural copy of the table or a hand-written one.
// ----------------------------------------------------------------------------
module tb_hashed_key_value_table_top;
    import hkvt_pkg::*;

    localparam int N_BKT        = NUM_BUCKETS_DEF;
    localparam int N_WAYS       = WAYS_DEF;
    localparam int RANDOM_ITEMS = 1200;
    localparam int IDLE_PCT     = 11;
    localparam int HOLD_CYCLES  = 400;      // long receiver hold-off
    localparam int DRAIN_CYCLES = 40;       // well past the response latency
    localparam int LIMIT_CYCLES = 200000;

    // mode 3 has no name in the package; the block must ignore it
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_req_valid = 1'b0;
    t_req i_req       = '0;
    logic i_rsp_ready = 1'b0;
    logic o_req_ready;
    logic o_rsp_valid;
    t_rsp o_rsp;

    hashed_key_value_table_top #(
        .NUM_BUCKETS (N_BKT),
        .WAYS        (N_WAYS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the table
    // ------------------------------------------------------------------
    logic [N_WAYS-1:0] way_used   [N_BKT];
    logic [KEY_W-1:0]  stored_key [N_BKT][N_WAYS];
    logic [VAL_W-1:0]  stored_val [N_BKT][N_WAYS];

    initial begin
        foreach (way_used[b]) way_used[b] = '0;   // all ways empty after reset
    end

    // Applies one request to the shadow table and returns its response.
    // Hash: key times 1009, kept to 32 bits, then modulo the bucket count.
    function automatic t_rsp table_access(t_req r);
        logic [KEY_W-1:0] k;
        logic [KEY_W-1:0] prod;
        int unsigned      b;
        int               hit;
        int               free_way;
        t_rsp             rsp;
        k        = r.key;
        prod     = k * HASH_MULT;
        b        = prod % N_BKT;
        hit      = -1;
        free_way = -1;
        for (int w = 0; w < N_WAYS; w++) begin
            if (way_used[b][w] && stored_key[b][w] == k && hit < 0) hit = w;
            if (!way_used[b][w] && free_way < 0) free_way = w;
        end
        rsp = '0;
        unique case (r.mode)
            MODE_PUT: begin
                if (hit >= 0) begin
                    rsp.found = 1'b1;
                    stored_val[b][hit] = r.value;
                end else if (free_way >= 0) begin
                    // lowest free way takes the new pair
                    stored_key[b][free_way] = k;
                    stored_val[b][free_way] = r.value;
                    way_used[b][free_way]   = 1'b1;
                end else begin
                    rsp.bucket_full = 1'b1;     // new key, no room: dropped
                end
            end
            MODE_GET: begin
                if (hit >= 0) begin
                    rsp.found      = 1'b1;
                    rsp.read_value = stored_val[b][hit];
                end else begin
                    rsp.read_value = MISS_VALUE;
                end
            end
            MODE_REMOVE: begin
                if (hit >= 0) begin
                    rsp.found          = 1'b1;
                    way_used[b][hit]   = 1'b0;
                end
            end
            default: ;                          // unused mode: all zero, no change
        endcase
        return rsp;
    endfunction

    // Responses still owed by the block, oldest first
    t_rsp awaited_rsp [$];
    int   mismatch_count = 0;

    // ------------------------------------------------------------------
    // Random key source: a few buckets (low 10 bits) crossed with a few
    // upper parts, so that buckets fill, overflow and hit often. Keys that
    // share their low 10 bits share a bucket, and as 1009 is odd, no others do.
    // ------------------------------------------------------------------
    logic [21:0] hi_pool [8];
    logic [9:0]  lo_pool [4];

    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 99) < 85)
            return {hi_pool[$urandom_range(0, 7)], lo_pool[$urandom_range(0, 3)]};
        return $urandom;                        // stray key, mostly a miss
    endfunction

    // ------------------------------------------------------------------
    // Gap control shared by both sides
    // ------------------------------------------------------------------
    logic no_gaps  = 1'b0;                      // stretch with no idling at all
    logic rsp_hold = 1'b0;                      // receiver holding off
    event hold_off_go;

    // Request side: random idle cycles, then offer until the transfer.
    // Valid is only lowered while idling, so it is never lowered and raised
    // within one step.
    task automatic send_request(input t_req r, input bit typed, input t_rsp typed_rsp);
        t_rsp predicted;
        while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
            i_req_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_req       <= r;
        i_req_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_req_ready) @(posedge i_clk);
        // shadow table always advances; typed rows override its answer
        predicted = table_access(r);
        awaited_rsp.insert(awaited_rsp.size(), typed ? typed_rsp : predicted);
    endtask

    // Response side ready: random stalls, the hold-off, or always ready
    always @(posedge i_clk) begin
        if (rsp_hold) begin
            i_rsp_ready <= 1'b0;
        end else if (no_gaps) begin
            i_rsp_ready <= 1'b1;
        end else begin
            i_rsp_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // One long hold-off, counted here, while requests keep coming so the
    // block backs up and drops o_req_ready
    initial begin
        @(hold_off_go);
        rsp_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rsp_hold <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Response checker
    // ------------------------------------------------------------------
    t_rsp head_rsp;

    always @(posedge i_clk) begin
        if (i_rst_n && o_rsp_valid && i_rsp_ready) begin
            if (awaited_rsp.size() == 0) begin
                $display("%0t: expected no response, actual %p", $time, o_rsp);
                mismatch_count++;
            end else begin
                head_rsp = awaited_rsp.pop_front();
                if (o_rsp.found !== head_rsp.found) begin
                    $display("%0t: found expected %0b actual %0b",
                             $time, head_rsp.found, o_rsp.found);
                    mismatch_count++;
                end
                if (o_rsp.read_value !== head_rsp.read_value) begin
                    $display("%0t: read_value expected %h actual %h",
                             $time, head_rsp.read_value, o_rsp.read_value);
                    mismatch_count++;
                end
                if (o_rsp.bucket_full !== head_rsp.bucket_full) begin
                    $display("%0t: bucket_full expected %0b actual %0b",
                             $time, head_rsp.bucket_full, o_rsp.bucket_full);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog
    int cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Scripted part
    // ------------------------------------------------------------------
    typedef struct {
        t_req req;
        bit   typed;        // response written in by hand
        t_rsp rsp;
    } t_script_line;

    t_script_line script [$];

    task automatic add_line(input logic [MODE_W-1:0] mode, input logic [31:0] key,
                            input logic [31:0] value, input int typed,
                            input int found, input logic [31:0] rd, input int full);
        t_script_line s;
        s.req.mode        = mode;
        s.req.key         = key;
        s.req.value       = value;
        s.typed           = 1'(typed);
        s.rsp.found       = 1'(found);
        s.rsp.read_value  = rd;
        s.rsp.bucket_full = 1'(full);
        script.insert(script.size(), s);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        t_req req;
        int   dice;

        hi_pool[0] = '0;
        hi_pool[1] = '1;                        // sign bit set
        for (int i = 2; i < 8; i++) hi_pool[i] = 22'($urandom);
        foreach (lo_pool[i]) lo_pool[i] = 10'($urandom);

        // Bucket 0 holds every key whose low 10 bits are zero
        add_line(MODE_GET,    32'h0000_0000, 32'h0000_0000, 1, 0, MISS_VALUE,    0); // empty
        add_line(MODE_REMOVE, 32'h0000_0000, 32'h0000_0000, 1, 0, 32'h0,        0); // absent
        add_line(MODE_PUT,    32'h8000_0000, 32'h7FFF_FFFF, 1, 0, 32'h0,        0);
        add_line(MODE_PUT,    32'h0000_0000, 32'h8000_0000, 1, 0, 32'h0,        0);
        add_line(MODE_PUT,    32'h0000_0400, 32'h0000_0001, 1, 0, 32'h0,        0);
        add_line(MODE_PUT,    32'h0000_0800, 32'hFFFF_FFFF, 1, 0, 32'h0,        0);
        add_line(MODE_PUT,    32'h0000_0C00, 32'h0000_0005, 1, 0, 32'h0,        1); // full
        add_line(MODE_GET,    32'h8000_0000, 32'h0000_0000, 1, 1, 32'h7FFF_FFFF, 0);
        add_line(MODE_GET,    32'h0000_0000, 32'hFFFF_FFFF, 1, 1, 32'h8000_0000, 0);
        add_line(MODE_PUT,    32'h0000_0000, 32'h1234_5678, 1, 1, 32'h0,        0); // overwrite
        add_line(MODE_GET,    32'h0000_0000, 32'h0000_0000, 0, 0, 32'h0,        0);
        add_line(MODE_REMOVE, 32'h0000_0400, 32'h0000_0000, 1, 1, 32'h0,        0);
        add_line(MODE_PUT,    32'h0000_0C00, 32'hDEAD_BEEF, 0, 0, 32'h0,        0); // reuse way
        add_line(MODE_GET,    32'h0000_0C00, 32'h0000_0000, 0, 0, 32'h0,        0);
        add_line(MODE_GET,    32'h0000_0400, 32'h0000_0000, 1, 0, MISS_VALUE,    0);
        add_line(MODE_UNUSED, 32'h8000_0000, 32'hFFFF_FFFF, 1, 0, 32'h0,        0); // ignored
        // 0x7FFFFFFF and 0xFFFFFFFF share a bucket
        add_line(MODE_PUT,    32'h7FFF_FFFF, 32'h0000_0000, 1, 0, 32'h0,        0);
        add_line(MODE_GET,    32'h7FFF_FFFF, 32'h0000_0000, 1, 1, 32'h0,        0);
        add_line(MODE_PUT,    32'hFFFF_FFFF, 32'h7FFF_FFFF, 0, 0, 32'h0,        0);
        add_line(MODE_GET,    32'hFFFF_FFFF, 32'h0000_0000, 0, 0, 32'h0,        0);
        add_line(MODE_REMOVE, 32'h7FFF_FFFF, 32'h0000_0000, 1, 1, 32'h0,        0);
        add_line(MODE_GET,    32'hFFFF_FFFF, 32'h0000_0000, 0, 0, 32'h0,        0);
        add_line(MODE_REMOVE, 32'h8000_0000, 32'h0000_0000, 1, 1, 32'h0,        0);
        add_line(MODE_GET,    32'h8000_0000, 32'h0000_0000, 1, 0, MISS_VALUE,    0);

        // Reset is held, then released; the clearing pass shows up as o_req_ready low
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i]) send_request(script[i].req, script[i].typed, script[i].rsp);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 200) -> hold_off_go;
            if (n == 500) no_gaps <= 1'b1;
            if (n == 700) no_gaps <= 1'b0;
            dice = $urandom_range(0, 99);
            if (dice < 40)      req.mode = MODE_PUT;
            else if (dice < 75) req.mode = MODE_GET;
            else if (dice < 95) req.mode = MODE_REMOVE;
            else                req.mode = MODE_UNUSED;
            req.key   = pick_key();
            req.value = $urandom;
            send_request(req, 1'b0, '0);
        end
        i_req_valid <= 1'b0;

        // drain, then give any stray response time to show up
        while (awaited_rsp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
